// ===== sv/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape unit.
package jsu_pkg;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [5:0]  UTF8_MASK  = 6'h3F;
  localparam logic [15:0] UTF8_TWO   = 16'h0080;
  localparam logic [15:0] UTF8_THREE = 16'h0800;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } out_item_t;

  // Results caused by one source byte: up to three bytes, index of the final one.
  typedef struct packed {
    logic [1:0] lst;
    logic [1:0] kind;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } grp_t;

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) v = 4'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) v = 4'(b - 8'h61 + 8'd10);
    else if (b >= 8'h41 && b <= 8'h46) v = 4'(b - 8'h41 + 8'd10);
    return v;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/jsu_front.sv =====
// Front end: parses source bytes and emits one result group per byte that causes any.
module jsu_front import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     grp_push,
  output grp_t     grp_data
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_STR,
    M_ESC,
    M_HEX
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        take;
  logic [7:0]  b;
  logic [15:0] code;

  assign take = in_push && !q_full;
  assign b    = in_data.in_byte;
  assign code = {acc_r[11:0], hex_value(b)};

  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    acc_nxt     = acc_r;
    grp_push    = 1'b0;
    grp_data    = '0;
    grp_data.kind = KIND_DATA;
    if (in_data.end_of_source) begin
      mode_nxt      = M_IDLE;
      hex_cnt_nxt   = 2'd0;
      acc_nxt       = 16'd0;
      grp_push      = 1'b1;
      grp_data.kind = KIND_ERROR;
    end else begin
      case (mode_r)
        M_STR: begin
          if (b == CH_QUOTE) begin
            mode_nxt      = M_IDLE;
            grp_push      = 1'b1;
            grp_data.kind = KIND_DONE;
          end else if (b == CH_BSLASH) begin
            mode_nxt = M_ESC;
          end else begin
            grp_push    = 1'b1;
            grp_data.b0 = b;
          end
        end
        M_ESC: begin
          if (b == CH_U) begin
            mode_nxt    = M_HEX;
            hex_cnt_nxt = 2'd0;
            acc_nxt     = 16'd0;
          end else begin
            mode_nxt    = M_STR;
            grp_push    = 1'b1;
            grp_data.b0 = escape_map(b);
          end
        end
        M_HEX: begin
          if (hex_cnt_r == 2'd3) begin
            mode_nxt    = M_STR;
            hex_cnt_nxt = 2'd0;
            acc_nxt     = 16'd0;
            grp_push    = 1'b1;
            if (code < UTF8_TWO) begin
              grp_data.b0 = code[7:0];
            end else if (code < UTF8_THREE) begin
              grp_data.lst = 2'd1;
              grp_data.b0  = UTF8_LEAD2 | {3'd0, code[10:6]};
              grp_data.b1  = UTF8_CONT | {2'd0, code[5:0] & UTF8_MASK};
            end else begin
              grp_data.lst = 2'd2;
              grp_data.b0  = UTF8_LEAD3 | {4'd0, code[15:12]};
              grp_data.b1  = UTF8_CONT | {2'd0, code[11:6] & UTF8_MASK};
              grp_data.b2  = UTF8_CONT | {2'd0, code[5:0] & UTF8_MASK};
            end
          end else begin
            acc_nxt     = code;
            hex_cnt_nxt = hex_cnt_r + 2'd1;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
          if (b == CH_QUOTE) begin
            mode_nxt    = M_STR;
            hex_cnt_nxt = 2'd0;
            acc_nxt     = 16'd0;
          end else if (b != CH_SPACE && b != CH_TAB && b != CH_LF && b != CH_CR) begin
            hex_cnt_nxt   = 2'd0;
            acc_nxt       = 16'd0;
            grp_push      = 1'b1;
            grp_data.kind = KIND_ERROR;
          end
        end
      endcase
    end
    if (!take) begin
      grp_push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      hex_cnt_r <= 2'd0;
      acc_r     <= 16'd0;
    end else if (take) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule

// ===== sv/jsu_fifo.sv =====
// Short queue of result groups between the front and back ends.
module jsu_fifo import jsu_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t push_data,
  input  logic pop,
  output grp_t pop_data,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  grp_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full     = cnt_r == FULL_CNT;
  assign empty    = cnt_r == '0;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT) else $error("queue count beyond depth");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r == rd_ptr_r) == (empty || full))
    else $error("queue pointers disagree with count");

endmodule

// ===== sv/jsu_back.sv =====
// Back end: splits result groups into single results held in an output register.
module jsu_back import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  grp_t      grp_data,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic       out_vld_r, out_vld_nxt;
  out_item_t  out_r, out_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       load;
  logic [7:0] sel;

  assign load      = !out_vld_r || out_pop;
  assign out_empty = !out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    case (idx_r)
      2'd1:    sel = grp_data.b1;
      2'd2:    sel = grp_data.b2;
      default: sel = grp_data.b0;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    idx_nxt     = idx_r;
    q_pop       = 1'b0;
    if (load) begin
      out_vld_nxt = !q_empty;
      if (!q_empty) begin
        out_nxt.out_byte = sel;
        out_nxt.kind     = grp_data.kind;
        out_nxt.last     = idx_r == grp_data.lst;
        if (idx_r == grp_data.lst) begin
          q_pop   = 1'b1;
          idx_nxt = 2'd0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      idx_r     <= 2'd0;
    end else begin
      out_vld_r <= out_vld_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.kind == KIND_DATA || out_data.kind == KIND_DONE ||
                    out_data.kind == KIND_ERROR))
    else $error("illegal result kind");
  a_ctl_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.kind != KIND_DATA |-> out_data.last && out_data.out_byte == 8'd0)
    else $error("status result malformed");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd3 && (!q_empty || idx_r == 2'd0))
    else $error("group index out of step");

endmodule

// ===== sv/json_string_unescape_utf8_unit.sv =====
// Top level of the JSON string unescape unit with UTF-8 encoding of \u escapes.
// Takes one source byte per cycle whenever in_full is low. Each byte gives zero to
// three results; results leave one per cycle through a registered output while
// out_pop takes them, so a \u escape that encodes to two or three bytes leaves as
// that many separate results. A queue of QDEPTH result groups between the parser and
// the output stage absorbs these bursts and output stalls; in_full rises only when
// it fills.
module json_string_unescape_utf8_unit import jsu_pkg::*; #(
  parameter int QDEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic grp_push, q_full, q_empty, q_pop;
  grp_t grp_in, grp_out;

  assign in_full = q_full;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .q_full   (q_full),
    .grp_push (grp_push),
    .grp_data (grp_in)
  );

  jsu_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (grp_push),
    .push_data (grp_in),
    .pop       (q_pop),
    .pop_data  (grp_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_data  (grp_out),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
